// ===== hdl/bounded_max_heap_queue_macros.svh =====
// assertion macros for the heap queue
`ifndef BOUNDED_MAX_HEAP_QUEUE_MACROS_SVH
`define BOUNDED_MAX_HEAP_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define BMHQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BMHQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bmhq_pkg.sv =====
`default_nettype none
package bmhq_pkg;
  localparam int HEAP_DEPTH = 64;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] new_key;
    logic [31:0]        new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_key;
    logic [31:0]        removed_value;
    logic signed [31:0] top_key;
    logic [6:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD_LAST, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_INS_CHK,
    S_UP_RD, S_UP_CMP, S_TOP_RD, S_TOP, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/bounded_max_heap_queue.sv =====
// from accept to response valid: insert checks the capacity, then climbs a level per
// parent read and compare (refused when full); extract reads the last entry, then descends
// a level per left read, right read and compare; replace runs both; then the top key is read
// one request at a time: a new request is accepted only in idle, after the response
// handshake, set by the one heap memory and one key comparator
// reset: synchronous active high rst empties the queue and sets capacity to 64
`default_nettype none
`include "bounded_max_heap_queue_macros.svh"
module bounded_max_heap_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bmhq_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bmhq_pkg::rsp_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [6:0]     cfg_data
);
  import bmhq_pkg::*;

  logic [63:0] mem [HEAP_DEPTH];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [63:0] wr_data;
  logic wr_en;

  state_t state, state_next;
  logic [6:0] capacity;
  logic [CW-1:0] count;
  logic [CW-1:0] cap_eff;
  req_t req;
  logic [AW-1:0] pos;
  logic [AW-1:0] parent;
  logic [AW+1:0] lc, rc;
  logic [63:0] cur;      // entry being sifted
  logic [63:0] best;     // larger of cur and left child
  logic sel_l;
  logic have_r;
  logic [1:0] status;
  logic [63:0] removed;
  logic [31:0] top;
  logic [31:0] cmp_a, cmp_b;
  logic cmp_lt;
  logic is_pop;

  // heap memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign cap_eff = (capacity > 7'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : CW'(capacity);

  // shared signed comparator: a < b
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  // heap index arithmetic
  assign parent = (pos - AW'(1)) >> 1;
  assign lc = {1'b0, pos, 1'b1};
  assign rc = {1'b0, pos, 1'b0} + (AW+2)'(2);
  assign is_pop = (req.opcode == OP_REPLACE) || (req.opcode == OP_EXTRACT);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (req.opcode == OP_INSERT) state_next = S_INS_CHK;
        else if (is_pop && count != '0) state_next = S_RD_LAST;
        else state_next = S_TOP_RD;
      end
      S_RD_LAST: state_next = S_DN_RDL;
      S_DN_RDL: begin
        if (lc < (AW+2)'(count)) state_next = S_DN_RDR;
        else if (req.opcode == OP_REPLACE) state_next = S_INS_CHK;
        else state_next = S_TOP_RD;
      end
      S_DN_RDR: state_next = S_DN_CMP;
      S_DN_CMP: begin
        if ((have_r && cmp_lt) || sel_l) state_next = S_DN_RDL;
        else if (req.opcode == OP_REPLACE) state_next = S_INS_CHK;
        else state_next = S_TOP_RD;
      end
      S_INS_CHK: state_next = (count >= cap_eff) ? S_TOP_RD : S_UP_RD;
      S_UP_RD:   state_next = (pos == '0) ? S_TOP_RD : S_UP_CMP;
      S_UP_CMP:  state_next = cmp_lt ? S_UP_RD : S_TOP_RD;
      S_TOP_RD:  state_next = S_TOP;
      S_TOP:     state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs, memory control and comparator operands
  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    cmp_a = best[63:32];
    cmp_b = rd_data[63:32];
    case (state)
      S_DECODE: rd_addr = AW'(count - CW'(1));
      S_DN_RDL: begin
        if (lc < (AW+2)'(count)) rd_addr = lc[AW-1:0];
        else wr_en = 1'b1;
      end
      S_DN_RDR: begin
        rd_addr = rc[AW-1:0];
        cmp_a = cur[63:32];
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (have_r && cmp_lt) wr_data = rd_data;
        else if (sel_l) wr_data = best;
      end
      S_UP_RD: begin
        if (pos == '0) wr_en = 1'b1;
        else rd_addr = parent;
      end
      S_UP_CMP: begin
        cmp_a = rd_data[63:32];
        cmp_b = cur[63:32];
        wr_en = 1'b1;
        if (cmp_lt) wr_data = rd_data;
      end
      default: ;
    endcase
    out_data.status        = status;
    out_data.removed_key   = removed[63:32];
    out_data.removed_value = removed[31:0];
    out_data.top_key       = (count == '0) ? 32'sd0 : top;
    out_data.entry_count   = 7'(count);
    out_data.is_empty      = (count == '0);
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req <= in_data;
          status <= ST_DONE;
          removed <= '0;
        end
      end
      S_DECODE: begin
        // rd_data holds the top entry, read while idle
        if (is_pop) begin
          if (count == '0) status <= ST_EMPTY;
          else begin
            removed <= rd_data;
            count <= count - CW'(1);
            pos <= '0;
          end
        end
      end
      S_RD_LAST: cur <= rd_data;
      S_DN_RDR: begin
        best <= cmp_lt ? rd_data : cur;
        sel_l <= cmp_lt;
        have_r <= rc < (AW+2)'(count);
      end
      S_DN_CMP: begin
        if (have_r && cmp_lt) pos <= rc[AW-1:0];
        else if (sel_l) pos <= lc[AW-1:0];
      end
      S_INS_CHK: begin
        if (count >= cap_eff) status <= ST_FULL;
        else begin
          cur <= {req.new_key, req.new_value};
          pos <= AW'(count);
          count <= count + CW'(1);
        end
      end
      S_UP_CMP: begin
        if (cmp_lt) pos <= parent;
      end
      S_TOP: top <= rd_data[63:32];
      default: ;
    endcase
    if (rst) begin
      count <= '0;
    end
  end

  // state and capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= 7'd64;
    end else begin
      state <= state_next;
      if (cfg_we) capacity <= cfg_data;
    end
  end

  `BMHQ_ASSERT_IMP(a_cnt_cap, clk, rst, 1'b1, count <= CW'(HEAP_DEPTH))
  `BMHQ_ASSERT_IMP(a_hs, clk, rst, 1'b1, !(in_ready && out_valid))
  `BMHQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `BMHQ_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
endmodule
`default_nettype wire
